// ----- src/slru_pkg.sv -----
// shared types and constants for the segmented lru page table
package slru_pkg;
  localparam int unsigned PageSlots = 64;
  localparam int unsigned SlotW = $clog2(PageSlots);
  localparam logic [31:0] NoPage = 32'hFFFF_FFFF;
  localparam logic [6:0] LimitReset = 7'd48;
  localparam logic [1:0] AddrLimit = 2'd0;

  typedef enum logic [3:0] {
    CmdLookup = 4'd0, CmdInsert = 4'd1, CmdRemove = 4'd2, CmdAccess = 4'd3,
    CmdDirty = 4'd4, CmdClean = 4'd5, CmdPin = 4'd6, CmdUnpin = 4'd7,
    CmdVictim = 4'd8
  } cmd_e;

  // scan kinds run by the datapath
  typedef enum logic [1:0] {
    ScanMatch = 2'd0, ScanFree = 2'd1, ScanOldProb = 2'd2, ScanOldProt = 2'd3
  } scan_e;

  typedef struct packed {
    logic         load;
    logic         scan_start;
    scan_e        scan_kind;
    logic         apply;
    logic         demote;
    logic         finish;
  } ctrl_t;

  typedef struct packed {
    logic             scan_done;
    logic             found;
    logic [SlotW-1:0] found_slot;
  } stat_t;
endpackage

// ----- src/slru_ram.sv -----
// generic single port ram with registered read
module slru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- src/slru_ctrl.sv -----
// sequencer for commands of the page table
module slru_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic [3:0]     cmd_i,
  input  logic           promote_i,
  input  logic           need_demote_i,
  input  logic           out_busy_i,
  input  slru_pkg::stat_t stat_i,
  output slru_pkg::ctrl_t ctrl_o,
  output logic           idle_o
);
  import slru_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StScan = 7'b0000010, StScan2 = 7'b0000100,
    StApply = 7'b0001000, StDemote = 7'b0010000, StOut = 7'b0100000,
    StWait = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] cmd_q;
  logic second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmd_q <= '0;
      second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      second_q <= second_d;
      if (in_fire_i) cmd_q <= cmd_i;
    end
  end

  always_comb begin
    state_d = state_q;
    second_d = second_q;
    ctrl_o = '0;
    ctrl_o.scan_kind = ScanMatch;
    case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          second_d = 1'b0;
          if (cmd_i > CmdVictim) begin
            state_d = StOut;
          end else begin
            ctrl_o.scan_start = 1'b1;
            state_d = StScan;
            if (cmd_i == CmdInsert) ctrl_o.scan_kind = ScanFree;
            else if (cmd_i == CmdVictim) ctrl_o.scan_kind = ScanOldProb;
          end
        end
      end
      StScan: begin
        if (stat_i.scan_done) begin
          if (cmd_q == CmdVictim && !stat_i.found && !second_q) begin
            ctrl_o.scan_start = 1'b1;
            ctrl_o.scan_kind = ScanOldProt;
            second_d = 1'b1;
          end else begin
            state_d = StApply;
          end
        end
      end
      StApply: begin
        ctrl_o.apply = 1'b1;
        if (promote_i && need_demote_i) begin
          ctrl_o.scan_start = 1'b1;
          ctrl_o.scan_kind = ScanOldProt;
          state_d = StScan2;
        end else begin
          state_d = StOut;
        end
      end
      StScan2: begin
        if (stat_i.scan_done) state_d = StDemote;
      end
      StDemote: begin
        ctrl_o.demote = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_busy_i) begin
          ctrl_o.finish = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (!out_busy_i) begin
          ctrl_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign idle_o = (state_q == StIdle);
endmodule

// ----- src/slru_dp.sv -----
// slot storage, scan unit and counters
module slru_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slru_pkg::ctrl_t ctrl_i,
  input  logic [3:0]      cmd_i,
  input  logic [31:0]     page_i,
  input  logic [31:0]     now_i,
  input  logic [6:0]      limit_i,
  output slru_pkg::stat_t stat_o,
  output logic            promote_o,
  output logic            need_demote_o,
  output logic            res_ok_o,
  output logic [5:0]      res_slot_o,
  output logic [31:0]     res_victim_o,
  output logic [34:0]     res_counts_o
);
  import slru_pkg::*;

  localparam int unsigned CntW = SlotW + 1;

  logic [3:0]  cmd_q, cmd_d;
  logic [31:0] page_q, page_d, now_q, now_d;

  // per-slot flags in flops, page id and stamp in ram
  logic [PageSlots-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [PageSlots-1:0] pinned_q, pinned_d, prot_q, prot_d;
  logic [CntW-1:0] used_q, used_d, dirtyc_q, dirtyc_d, pinc_q, pinc_d;
  logic [CntW-1:0] protc_q, protc_d, probc_q, probc_d;

  // scan
  logic             scanning_q, scanning_d;
  scan_e            kind_q, kind_d;
  logic             excl_q, excl_d;
  logic [SlotW-1:0] idx_q, idx_d, best_q, best_d;
  logic [CntW-1:0]  step_q, step_d;
  logic             found_q, found_d;
  logic [31:0]      best_stamp_q, best_stamp_d;
  logic [SlotW-1:0] sel_q, sel_d;
  logic             sel_ok_q, sel_ok_d;
  logic             rd_match_q, rd_match_d, rd_old_q, rd_old_d;
  logic [SlotW-1:0] rd_idx_q, rd_idx_d;
  stat_t            stat_q, stat_d;

  // rams
  logic             pr_we, st_we;
  logic [SlotW-1:0] ram_addr;
  logic [31:0]      pr_wdata, pr_rdata, st_rdata;

  logic cand, touch, last_idx, step_done, take_match, take_old;

  slru_ram #(.Width(32), .Depth(PageSlots)) u_page (
    .clk_i(clk_i), .we_i(pr_we), .addr_i(ram_addr), .wdata_i(pr_wdata), .rdata_o(pr_rdata)
  );

  slru_ram #(.Width(32), .Depth(PageSlots)) u_stamp (
    .clk_i(clk_i), .we_i(st_we), .addr_i(ram_addr), .wdata_i(now_q), .rdata_o(st_rdata)
  );

  // a valid entry holds at least one hit, so any touch of a probation entry reaches two
  assign touch = (cmd_q == CmdAccess) || (cmd_q == CmdDirty);
  assign promote_o = sel_ok_q && touch && !prot_q[sel_q];
  assign need_demote_o = protc_q >= limit_i;

  // candidate test at a slot (flags only); the demotion scan skips the promoted slot
  always_comb begin
    case (kind_q)
      ScanFree:    cand = !valid_q[idx_q];
      ScanOldProb: cand = valid_q[idx_q] && !pinned_q[idx_q] && !prot_q[idx_q];
      ScanOldProt: cand = valid_q[idx_q] && !pinned_q[idx_q] && prot_q[idx_q] &&
                          !(excl_q && idx_q == sel_q);
      default:     cand = valid_q[idx_q];
    endcase
  end

  assign last_idx = (step_q == CntW'(PageSlots - 1));
  assign step_done = (step_q == CntW'(PageSlots));
  // registered ram reads are compared in the cycle after the address
  assign take_match = rd_match_q && !found_q && (pr_rdata == page_q);
  assign take_old = rd_old_q && (!found_q || st_rdata < best_stamp_q);

  assign ram_addr = scanning_q ? idx_q : sel_q;
  assign pr_we = ctrl_i.apply && sel_ok_q &&
                 ((cmd_q == CmdInsert) || (cmd_q == CmdRemove));
  assign pr_wdata = (cmd_q == CmdInsert) ? page_q : NoPage;
  assign st_we = ctrl_i.apply && sel_ok_q && ((cmd_q == CmdInsert) || touch);

  always_comb begin
    cmd_d = cmd_q; page_d = page_q; now_d = now_q;
    valid_d = valid_q; dirty_d = dirty_q; pinned_d = pinned_q; prot_d = prot_q;
    used_d = used_q; dirtyc_d = dirtyc_q; pinc_d = pinc_q;
    protc_d = protc_q; probc_d = probc_q;
    scanning_d = scanning_q; kind_d = kind_q; excl_d = excl_q;
    idx_d = idx_q; best_d = best_q; step_d = step_q; found_d = found_q;
    best_stamp_d = best_stamp_q; sel_d = sel_q; sel_ok_d = sel_ok_q;
    rd_match_d = 1'b0; rd_old_d = 1'b0; rd_idx_d = rd_idx_q;
    stat_d = stat_q;
    stat_d.scan_done = 1'b0;

    if (ctrl_i.load) begin
      cmd_d = cmd_i; page_d = page_i; now_d = now_i;
      sel_ok_d = 1'b0;
      sel_d = '0;
    end

    if (ctrl_i.scan_start) begin
      scanning_d = 1'b1;
      kind_d = ctrl_i.scan_kind;
      excl_d = ctrl_i.apply;
      idx_d = '0; step_d = '0;
      found_d = 1'b0;
      // invalid id: every command but victim finishes its scan at once
      if (ctrl_i.load && page_i == NoPage &&
          (ctrl_i.scan_kind == ScanMatch || ctrl_i.scan_kind == ScanFree)) begin
        scanning_d = 1'b0;
        stat_d = '{scan_done: 1'b1, found: 1'b0, found_slot: '0};
      end
    end else if (scanning_q) begin
      // one slot per cycle
      rd_match_d = (kind_q == ScanMatch) && cand;
      rd_old_d = (kind_q == ScanOldProb || kind_q == ScanOldProt) && cand;
      rd_idx_d = idx_q;
      if (take_match || take_old) begin
        found_d = 1'b1; best_d = rd_idx_q;
      end
      if (take_old) best_stamp_d = st_rdata;
      if (kind_q == ScanFree && cand && !found_q) begin
        found_d = 1'b1; best_d = idx_q;
      end
      if (step_done) begin
        scanning_d = 1'b0;
        rd_match_d = 1'b0;
        rd_old_d = 1'b0;
        stat_d.scan_done = 1'b1;
        stat_d.found = found_d;
        stat_d.found_slot = best_d;
        if (!excl_q) begin
          sel_d = best_d; sel_ok_d = found_d;
        end
      end else begin
        step_d = step_q + 1'b1;
        if (!last_idx) idx_d = idx_q + 1'b1;
      end
    end

    if (ctrl_i.apply && sel_ok_q) begin
      case (cmd_q)
        CmdInsert: begin
          valid_d[sel_q] = 1'b1; dirty_d[sel_q] = 1'b0; pinned_d[sel_q] = 1'b0;
          prot_d[sel_q] = 1'b0;
          used_d = used_q + 1'b1; probc_d = probc_q + 1'b1;
        end
        CmdRemove: begin
          if (dirty_q[sel_q]) dirtyc_d = dirtyc_q - 1'b1;
          if (pinned_q[sel_q]) pinc_d = pinc_q - 1'b1;
          if (prot_q[sel_q]) protc_d = protc_q - 1'b1;
          else probc_d = probc_q - 1'b1;
          used_d = used_q - 1'b1;
          valid_d[sel_q] = 1'b0; dirty_d[sel_q] = 1'b0; pinned_d[sel_q] = 1'b0;
          prot_d[sel_q] = 1'b0;
        end
        CmdAccess, CmdDirty: begin
          if (cmd_q == CmdDirty && !dirty_q[sel_q]) begin
            dirty_d[sel_q] = 1'b1; dirtyc_d = dirtyc_q + 1'b1;
          end
          if (promote_o) begin
            prot_d[sel_q] = 1'b1;
            protc_d = protc_q + 1'b1;
            probc_d = probc_q - 1'b1;
          end
        end
        CmdClean: if (dirty_q[sel_q]) begin
          dirty_d[sel_q] = 1'b0; dirtyc_d = dirtyc_q - 1'b1;
        end
        CmdPin: if (!pinned_q[sel_q]) begin
          pinned_d[sel_q] = 1'b1; pinc_d = pinc_q + 1'b1;
        end
        CmdUnpin: if (pinned_q[sel_q]) begin
          pinned_d[sel_q] = 1'b0; pinc_d = pinc_q - 1'b1;
        end
        default: ;
      endcase
    end

    // demotion scan ran after the promotion and skipped the promoted slot
    if (ctrl_i.demote && stat_q.found) begin
      prot_d[stat_q.found_slot] = 1'b0;
      protc_d = protc_q - 1'b1;
      probc_d = probc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0; page_q <= '0; now_q <= '0;
      valid_q <= '0; dirty_q <= '0; pinned_q <= '0; prot_q <= '0;
      used_q <= '0; dirtyc_q <= '0; pinc_q <= '0; protc_q <= '0; probc_q <= '0;
      scanning_q <= 1'b0; kind_q <= ScanMatch; excl_q <= 1'b0;
      idx_q <= '0; best_q <= '0; step_q <= '0; found_q <= 1'b0;
      best_stamp_q <= '0; sel_q <= '0; sel_ok_q <= 1'b0;
      rd_match_q <= 1'b0; rd_old_q <= 1'b0; rd_idx_q <= '0;
      stat_q <= '0;
    end else begin
      cmd_q <= cmd_d; page_q <= page_d; now_q <= now_d;
      valid_q <= valid_d; dirty_q <= dirty_d; pinned_q <= pinned_d; prot_q <= prot_d;
      used_q <= used_d; dirtyc_q <= dirtyc_d; pinc_q <= pinc_d;
      protc_q <= protc_d; probc_q <= probc_d;
      scanning_q <= scanning_d; kind_q <= kind_d; excl_q <= excl_d;
      idx_q <= idx_d; best_q <= best_d; step_q <= step_d; found_q <= found_d;
      best_stamp_q <= best_stamp_d; sel_q <= sel_d; sel_ok_q <= sel_ok_d;
      rd_match_q <= rd_match_d; rd_old_q <= rd_old_d; rd_idx_q <= rd_idx_d;
      stat_q <= stat_d;
    end
  end

  assign stat_o = stat_q;
  assign res_ok_o = sel_ok_q;
  assign res_slot_o = sel_ok_q ? 6'(sel_q) : 6'd0;
  assign res_victim_o = (sel_ok_q && cmd_q == CmdVictim) ? pr_rdata : NoPage;
  assign res_counts_o = {probc_q, protc_q, pinc_q, dirtyc_q, used_q};
endmodule

// ----- src/slru_page_table.sv -----
// segmented lru page table top level
// steps: one scan over all slots per command; a second scan for a victim query that falls back
//   to the protected segment or a promotion that demotes; no scan for an unused command or for
//   an invalid page id in any command but a victim query
// throughput: one command in flight; the next is taken once the result is registered
// reset: asynchronous active low; slots invalid, counts zero, protected_limit 48
module slru_page_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // command[3:0] page_id[35:4] tier[37:36] now[69:38]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // ok slot victim_page used dirty pinned prot prob
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slru_pkg::*;

  logic [6:0] limit_q;
  ctrl_t ctrl;
  stat_t stat;
  logic idle, in_fire, promote, need_demote;
  logic res_ok;
  logic [5:0] res_slot;
  logic [31:0] res_victim;
  logic [34:0] res_counts;
  logic out_v_q;
  logic [79:0] out_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrLimit) ? {25'd0, limit_q} : 32'd0;

  // configuration register; the page id and stamp stores' read data is only used at valid slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimitReset;
    else if (psel && penable && pwrite && paddr == AddrLimit) limit_q <= pwdata[6:0];
  end

  assign s_axis_tready_o = idle;
  assign in_fire = s_axis_tvalid_i && idle;

  slru_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .cmd_i(s_axis_tdata_i[3:0]),
    .promote_i(promote), .need_demote_i(need_demote),
    .out_busy_i(out_v_q && !m_axis_tready_i), .stat_i(stat), .ctrl_o(ctrl), .idle_o(idle)
  );

  // tier is not kept: no result depends on it
  slru_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .cmd_i(s_axis_tdata_i[3:0]),
    .page_i(s_axis_tdata_i[35:4]),
    .now_i(s_axis_tdata_i[69:38]), .limit_i(limit_q), .stat_o(stat),
    .promote_o(promote), .need_demote_o(need_demote), .res_ok_o(res_ok),
    .res_slot_o(res_slot), .res_victim_o(res_victim), .res_counts_o(res_counts)
  );

  // result register toward the master side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (ctrl.finish) out_v_q <= 1'b1;
    else if (m_axis_tready_i) out_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl.finish) out_q <= {6'd0, res_counts, res_victim, res_slot, res_ok};
  end
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = out_q;
endmodule

// ----- src/slru_checker.sv -----
// port level checks for the page table
module slru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)) else $error("hold");
  a_noslot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[6:1] == 6'd0) else $error("slot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o) else $error("busy");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[45:39] <= 7'd64) else $error("used");
endmodule

bind slru_page_table slru_checker u_chk (.*);

// ----- tb/slru_page_table_chk.sv -----
// checker for the segmented lru page table: predicts every result and compares
module slru_page_table_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  import slru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0]  prob;
    logic [6:0]  prot;
    logic [6:0]  pinned;
    logic [6:0]  dirty;
    logic [6:0]  used;
    logic [31:0] victim;
    logic [5:0]  slot;
    logic        ok;
  } lookup_res_t;

  logic [31:0] pg_id [PageSlots];
  logic        pg_valid [PageSlots];
  logic        pg_dirty [PageSlots];
  logic        pg_pinned [PageSlots];
  logic        pg_prot [PageSlots];
  logic [15:0] pg_hits [PageSlots];
  logic [31:0] pg_stamp [PageSlots];
  int          n_used, n_dirty, n_pinned, n_prot, n_prob;
  logic [6:0]  prot_limit;
  lookup_res_t awaited_q[$];

  assign pending_o = awaited_q.size();

  function automatic int find_slot(logic [31:0] pid);
    if (pid == NoPage) return -1;
    for (int i = 0; i < PageSlots; i++)
      if (pg_valid[i] && pg_id[i] == pid) return i;
    return -1;
  endfunction

  function automatic int oldest_slot(logic want_prot);
    int best;
    best = -1;
    for (int i = 0; i < PageSlots; i++) begin
      if (!pg_valid[i] || pg_pinned[i] || pg_prot[i] != want_prot) continue;
      if (best < 0 || pg_stamp[i] < pg_stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic void touch_slot(int s, logic [31:0] tick);
    int d;
    if (pg_hits[s] != 16'hFFFF) pg_hits[s]++;
    pg_stamp[s] = tick;
    if (!pg_prot[s] && pg_hits[s] >= 2) begin
      // promotion past the limit demotes the oldest unpinned protected entry
      if (n_prot >= prot_limit) begin
        d = oldest_slot(1'b1);
        if (d >= 0) begin
          pg_prot[d] = 1'b0;
          n_prot--;
          n_prob++;
        end
      end
      pg_prot[s] = 1'b1;
      n_prob--;
      n_prot++;
    end
  endfunction

  function automatic lookup_res_t predict_page_op(logic [71:0] d);
    lookup_res_t r;
    logic [3:0]  cmd;
    logic [31:0] pid, tick;
    int s;
    cmd  = d[3:0];
    pid  = d[35:4];
    tick = d[69:38];
    s = -1;
    r = '0;
    r.victim = NoPage;
    if (cmd == CmdInsert) begin
      if (pid != NoPage) begin
        for (int i = 0; i < PageSlots; i++)
          if (!pg_valid[i]) begin
            s = i;
            break;
          end
        if (s >= 0) begin
          pg_id[s] = pid;
          pg_valid[s] = 1'b1;
          pg_dirty[s] = 1'b0;
          pg_pinned[s] = 1'b0;
          pg_prot[s] = 1'b0;
          pg_hits[s] = 16'd1;
          pg_stamp[s] = tick;
          n_used++;
          n_prob++;
        end
      end
    end else if (cmd == CmdVictim) begin
      s = oldest_slot(1'b0);
      if (s < 0) s = oldest_slot(1'b1);
      if (s >= 0) r.victim = pg_id[s];
    end else if (cmd <= CmdUnpin) begin
      s = find_slot(pid);
      if (s >= 0) begin
        case (cmd)
          CmdRemove: begin
            if (pg_dirty[s]) n_dirty--;
            if (pg_pinned[s]) n_pinned--;
            if (pg_prot[s]) n_prot--;
            else n_prob--;
            n_used--;
            pg_valid[s] = 1'b0;
            pg_dirty[s] = 1'b0;
            pg_pinned[s] = 1'b0;
            pg_prot[s] = 1'b0;
            pg_id[s] = NoPage;
          end
          CmdAccess: touch_slot(s, tick);
          CmdDirty: begin
            if (!pg_dirty[s]) begin
              pg_dirty[s] = 1'b1;
              n_dirty++;
            end
            touch_slot(s, tick);
          end
          CmdClean: if (pg_dirty[s]) begin
            pg_dirty[s] = 1'b0;
            n_dirty--;
          end
          CmdPin: if (!pg_pinned[s]) begin
            pg_pinned[s] = 1'b1;
            n_pinned++;
          end
          CmdUnpin: if (pg_pinned[s]) begin
            pg_pinned[s] = 1'b0;
            n_pinned--;
          end
          default: ;
        endcase
      end
    end
    r.ok = (s >= 0);
    r.slot = (s >= 0) ? s[5:0] : 6'd0;
    r.used = n_used[6:0];
    r.dirty = n_dirty[6:0];
    r.pinned = n_pinned[6:0];
    r.prot = n_prot[6:0];
    r.prob = n_prob[6:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, exp_v, act_v);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < PageSlots; i++) begin
        pg_id[i] = NoPage;
        pg_valid[i] = 1'b0;
        pg_dirty[i] = 1'b0;
        pg_pinned[i] = 1'b0;
        pg_prot[i] = 1'b0;
        pg_hits[i] = '0;
        pg_stamp[i] = '0;
      end
      {n_used, n_dirty, n_pinned, n_prot, n_prob} = '0;
      prot_limit = LimitReset;
      awaited_q.delete();
      errors_o = 0;
    end else begin
      // register write lands at the access phase
      if (psel && penable && pwrite && pready && paddr == AddrLimit)
        prot_limit = pwdata[6:0];
      // result transfer
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[73:0];
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result transfer %0h", $realtime, m_axis_tdata_i);
          errors_o++;
        end else begin
          want = awaited_q.pop_front();
          if (got.ok !== want.ok) report("ok", want.ok, got.ok);
          if (got.slot !== want.slot) report("slot", want.slot, got.slot);
          if (got.victim !== want.victim) report("victim_page", want.victim, got.victim);
          if (got.used !== want.used) report("used_total", want.used, got.used);
          if (got.dirty !== want.dirty) report("dirty_total", want.dirty, got.dirty);
          if (got.pinned !== want.pinned) report("pinned_total", want.pinned, got.pinned);
          if (got.prot !== want.prot) report("protected_total", want.prot, got.prot);
          if (got.prob !== want.prob) report("probation_total", want.prob, got.prob);
        end
      end
      // command transfer
      if (s_axis_tvalid_i && s_axis_tready_i)
        awaited_q.push_back(predict_page_op(s_axis_tdata_i));
    end
  end
endmodule

// ----- tb/slru_page_table_tb.sv -----
// testbench top for the segmented lru page table: stimulus and verdict
module slru_page_table_tb;
  import slru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSize = 20;
  localparam int DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;   // command[3:0] page_id[35:4] tier[37:36] now[69:38]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;        // ok slot victim_page used dirty pinned prot prob
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;

  logic [31:0] page_pool [PoolSize];
  logic [31:0] tick = 32'd100;
  bit          sink_on = 1'b0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  slru_page_table dut (.*);

  slru_page_table_chk u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // result side: tready stalls at random, with a stall-free stretch while sink_on is clear
  always @(posedge clk_i) begin
    int hold;
    if (!sink_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (hold > 0) begin
      hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      hold = pick_gap();
      m_axis_tready_i <= (hold == 0);
    end
  end

  // one command transfer; tvalid stays high straight into the next item when no gap
  task automatic send_cmd(cmd_e cmd, logic [31:0] pid, logic [1:0] tier, logic [31:0] now,
                          logic [3:0] raw = 4'd0, bit use_raw = 1'b0, bit gaps = 1'b1);
    int gap;
    s_axis_tdata_i <= {2'b00, now, tier, pid, use_raw ? raw : 4'(cmd)};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] lim);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrLimit;
    pwdata <= {25'd0, lim};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] next_tick();
    int r;
    r = $urandom_range(99);
    if (r < 70) tick += $urandom_range(1, 5);
    else if (r < 85) ;                  // repeat the stamp to force ties
    else if (r < 95) tick = $urandom();
    else tick = (r & 1) ? 32'hFFFF_FFFF : 32'd0;
    return tick;
  endfunction

  function automatic logic [31:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 88) return page_pool[$urandom_range(PoolSize - 1)];
    if (r < 93) return NoPage;
    return $urandom();
  endfunction

  // ins_pct sets how hard a phase pushes the table toward full
  task automatic random_phase(int count, int ins_pct);
    int r;
    cmd_e c;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_cmd(CmdLookup, pick_page(), 2'($urandom()), next_tick(),
                 4'($urandom_range(9, 15)), 1'b1);
        continue;
      end
      if (r < 3 + ins_pct) c = CmdInsert;
      else c = cmd_e'($urandom_range(0, 8));
      send_cmd(c, pick_page(), 2'($urandom()), next_tick());
    end
  endtask

  initial begin
    for (int i = 0; i < PoolSize; i++) page_pool[i] = $urandom();
    page_pool[0] = 32'd0;
    page_pool[1] = 32'hFFFF_FFFE;
    page_pool[2] = 32'h5555_5555;
    page_pool[3] = 32'hAAAA_AAAA;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command, edge ids and stamps, refused and duplicate inserts
    write_limit(7'd1);
    send_cmd(CmdVictim, 32'd0, 2'd0, 32'd0, 4'd0, 1'b0, 1'b0);
    send_cmd(CmdInsert, 32'd0, 2'd3, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0);
    send_cmd(CmdInsert, NoPage, 2'd0, 32'd5, 4'd0, 1'b0, 1'b0);
    send_cmd(CmdInsert, 32'hFFFF_FFFE, 2'd1, 32'd0, 4'd0, 1'b0, 1'b0);
    send_cmd(CmdInsert, 32'd0, 2'd2, 32'd7);        // second copy of a present id
    send_cmd(CmdLookup, 32'd0, 2'd0, 32'd8);
    send_cmd(CmdLookup, NoPage, 2'd0, 32'd8);       // invalid id never hits
    send_cmd(CmdLookup, 32'h1234_5678, 2'd0, 32'd8); // miss
    send_cmd(CmdAccess, 32'd0, 2'd0, 32'd10);       // promote
    send_cmd(CmdDirty, 32'hFFFF_FFFE, 2'd0, 32'd11); // promote past limit, demotes
    send_cmd(CmdVictim, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdPin, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdPin, 32'd0, 2'd0, 32'd0);           // no change on second pin
    send_cmd(CmdAccess, 32'd0, 2'd0, 32'd12);
    send_cmd(CmdVictim, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdClean, 32'hFFFF_FFFE, 2'd0, 32'd0);
    send_cmd(CmdClean, 32'hFFFF_FFFE, 2'd0, 32'd0);
    send_cmd(CmdUnpin, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdUnpin, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdLookup, 32'd0, 2'd0, 32'd0, 4'd15, 1'b1); // unused command
    send_cmd(CmdLookup, 32'd0, 2'd0, 32'd0, 4'd9, 1'b1);
    send_cmd(CmdRemove, 32'd0, 2'd0, 32'd0);
    send_cmd(CmdRemove, 32'd0, 2'd0, 32'd0);        // the duplicate goes next
    send_cmd(CmdRemove, 32'd0, 2'd0, 32'd0);        // now a miss
    send_cmd(CmdVictim, 32'd0, 2'd0, 32'd0);

    // random phases over several limits, sender pausing until drained between them
    settle();
    write_limit(7'd0);
    sink_on = 1'b1;
    random_phase(100, 20);
    settle();
    write_limit(7'd64);
    random_phase(110, 55);                          // drives the table to full
    settle();
    write_limit(7'd2);
    random_phase(110, 15);
    settle();
    write_limit(7'd127);
    random_phase(100, 20);
    settle();
    write_limit(LimitReset);
    sink_on = 1'b0;
    random_phase(30, 20);
    settle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
